FILE: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// The condition must hold at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, cond) \
	label: assert property (@(posedge clk) (cond)) \
		else $error("invariant check failed");

`endif

FILE: sv/pli_pkg.sv
package pli_pkg;

	localparam int NODES = 8;
	localparam int FRAC_BITS = 16;

	localparam int DATA_W = 32;
	localparam int NODE_IDX_W = 3;
	localparam int NODES_W = 4;
	localparam int STATUS_W = 2;
	localparam int IDX_W = $clog2(NODES);
	localparam int QUOT_W = FRAC_BITS + 1;
	localparam int STEP_W = $clog2(QUOT_W + 1);
	localparam int PROD_W = QUOT_W + 1 + DATA_W + 1;

	// Command queue between the front and the back; the depth must be a power of two.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_NODES = 3'd0;

	localparam logic [NODES_W-1:0] NODES_RESET = 4'd2;
	localparam logic [NODES_W-1:0] NODES_MIN = 4'd2;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_INTERP = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BELOW = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ABOVE = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FLAT = 2'd3;

	typedef struct packed {
		logic query;
		logic [IDX_W-1:0] idx;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic [DATA_W-1:0] num;
		logic [DATA_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: sv/pli_if.sv
interface pli_in_if import pli_pkg::*; ();
	logic valid;
	logic ready;
	logic [0:0] kind;
	logic [NODE_IDX_W-1:0] node_index;
	logic signed [DATA_W-1:0] point_x;
	logic signed [DATA_W-1:0] point_y;

	modport source (output valid, kind, node_index, point_x, point_y, input ready);
	modport sink (input valid, kind, node_index, point_x, point_y, output ready);
endinterface

interface pli_out_if import pli_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DATA_W-1:0] interp_value;
	logic [STATUS_W-1:0] status;

	modport source (output valid, interp_value, status, input ready);
	modport sink (input valid, interp_value, status, output ready);
endinterface

FILE: sv/pli_div.sv
module pli_div import pli_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);

	logic [DATA_W:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic [QUOT_W-1:0] quot_q;
	logic [STEP_W-1:0] step_q;
	logic busy_q;
	logic done_q;
	logic ge;
	logic [DATA_W:0] diff;
	logic [DATA_W:0] rem_next;

	// Restoring division, one quotient bit per cycle. The caller must keep the numerator
	// within the divisor, which this block does not check; the remainder then stays below twice the divisor.
	assign ge = rem_q >= {1'b0, den_q};
	assign diff = rem_q - {1'b0, den_q};
	assign rem_next = ge ? diff : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUOT_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.num};
			den_q <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_next[DATA_W-1:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

FILE: sv/pli_front.sv
module pli_front import pli_pkg::*; (
	input logic clk,
	input logic arst_n,
	pli_in_if.sink req,
	output cmd_t cmd,
	output logic cmd_valid,
	input logic cmd_pop
);

	cmd_t fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;
	cmd_t entry;
	logic keep;
	logic push;

	assign req.ready = count_q != (QPTR_W + 1)'(QDEPTH);

	// Loads aimed beyond the table are dropped here and never reach the back.
	always_comb begin
		entry.query = req.kind == KIND_QUERY;
		entry.idx = IDX_W'(req.node_index);
		entry.x = req.point_x;
		entry.y = req.point_y;
		keep = entry.query || (int'(req.node_index) < NODES);
	end

	assign push = req.valid && req.ready && keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, cmd_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	assign cmd_valid = count_q != '0;
	assign cmd = fifo_q[rd_ptr_q];

endmodule

FILE: sv/pli_back.sv
module pli_back import pli_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	input logic cmd_valid,
	output logic cmd_pop,
	input logic [NODES_W-1:0] nodes_in_use,
	output div_req_t div_req,
	input div_rsp_t div_rsp,
	pli_out_if.source rsp
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FIRST = 3'd1;
	localparam logic [2:0] S_LAST = 3'd2;
	localparam logic [2:0] S_SRCH = 3'd3;
	localparam logic [2:0] S_LEFT = 3'd4;
	localparam logic [2:0] S_DIV = 3'd5;
	localparam logic [2:0] S_ADD = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q;
	logic signed [DATA_W-1:0] x_tab_q [NODES];
	logic signed [DATA_W-1:0] y_tab_q [NODES];
	logic [IDX_W-1:0] rd_q;
	logic [IDX_W-1:0] last_q;
	logic signed [DATA_W-1:0] px_q;
	logic signed [DATA_W-1:0] xr_q;
	logic signed [DATA_W-1:0] yr_q;
	logic signed [DATA_W-1:0] yl_q;
	logic signed [DATA_W:0] dy_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DATA_W-1:0] res_q;
	logic [STATUS_W-1:0] stat_q;
	logic out_valid_q;
	logic signed [DATA_W-1:0] out_val_q;
	logic [STATUS_W-1:0] out_stat_q;

	logic signed [DATA_W-1:0] rx;
	logic signed [DATA_W-1:0] ry;
	logic signed [DATA_W:0] dx;
	logic signed [DATA_W:0] num;
	logic dx_pos;
	logic signed [PROD_W-1:0] prod_sh;
	logic [IDX_W-1:0] last_idx;
	logic out_free;
	logic table_wr;

	assign rx = x_tab_q[rd_q];
	assign ry = y_tab_q[rd_q];
	assign dx = {xr_q[DATA_W-1], xr_q} - {rx[DATA_W-1], rx};
	assign num = {px_q[DATA_W-1], px_q} - {rx[DATA_W-1], rx};
	assign dx_pos = !dx[DATA_W] && (dx != '0);
	assign prod_sh = prod_q >>> FRAC_BITS;
	assign out_free = !out_valid_q || rsp.ready;

	// Node counts outside the table's range are pulled back to the nearest legal one.
	always_comb begin
		if (nodes_in_use < NODES_MIN) begin
			last_idx = IDX_W'(1);
		end else if (int'(nodes_in_use) > NODES) begin
			last_idx = IDX_W'(NODES - 1);
		end else begin
			last_idx = IDX_W'(nodes_in_use - 1'b1);
		end
	end

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;
	assign table_wr = cmd_pop && !cmd.query;

	assign div_req.start = (state_q == S_LEFT) && dx_pos;
	assign div_req.num = num[DATA_W-1:0];
	assign div_req.den = dx[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop && cmd.query) begin
						state_q <= S_FIRST;
					end
				end
				S_FIRST: begin
					if (px_q <= rx) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					if (px_q >= rx) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (px_q <= rx || rd_q == last_q) begin
						state_q <= S_LEFT;
					end
				end
				S_LEFT: begin
					state_q <= dx_pos ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (table_wr) begin
			x_tab_q[cmd.idx] <= cmd.x;
			y_tab_q[cmd.idx] <= cmd.y;
		end
	end

	// The search walks the right end of the segment upwards from the second node.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_pop) begin
					px_q <= cmd.x;
					rd_q <= '0;
					last_q <= last_idx;
				end
			end
			S_FIRST: begin
				res_q <= ry;
				stat_q <= STAT_BELOW;
				rd_q <= last_q;
			end
			S_LAST: begin
				res_q <= ry;
				stat_q <= STAT_ABOVE;
				rd_q <= IDX_W'(1);
			end
			S_SRCH: begin
				if (px_q <= rx || rd_q == last_q) begin
					xr_q <= rx;
					yr_q <= ry;
					rd_q <= rd_q - 1'b1;
				end else begin
					rd_q <= rd_q + 1'b1;
				end
			end
			S_LEFT: begin
				res_q <= ry;
				yl_q <= ry;
				dy_q <= {yr_q[DATA_W-1], yr_q} - {ry[DATA_W-1], ry};
				stat_q <= dx_pos ? STAT_INTERP : STAT_FLAT;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					prod_q <= $signed({1'b0, div_rsp.quot}) * dy_q;
				end
			end
			S_ADD: begin
				res_q <= yl_q + prod_sh[DATA_W-1:0];
			end
			S_DONE: begin
				if (out_free) begin
					out_val_q <= res_q;
					out_stat_q <= stat_q;
				end
			end
			default: begin
				rd_q <= rd_q;
			end
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.interp_value = out_val_q;
	assign rsp.status = out_stat_q;

endmodule

FILE: sv/piecewise_linear_interpolator.sv
// Load words go into the table as the back end pops them; each needs one queue slot on the way in.
// A query ends clamped below at the first node or clamped above at the last node; otherwise the
// node walk finds its segment, which gives the left node's y if its width is not positive and
// else runs the restoring divider, one multiply and one add; output stalls delay the result word.
// Queries pass one at a time: the back end pops its next word in the cycle the result appears.
// Asynchronous active-low reset empties the queue, idles the sequencer and sets nodes_in_use to 2.
module piecewise_linear_interpolator import pli_pkg::*; (
	input logic clk,
	input logic arst_n,
	pli_in_if.sink req,
	pli_out_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready
);

	logic [NODES_W-1:0] nodes_q;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic sel_nodes;

	assign pready = 1'b1;
	assign sel_nodes = paddr[PADDR_W-1:2] == ADDR_NODES[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= NODES_RESET;
		end else if (psel && penable && pwrite && sel_nodes) begin
			nodes_q <= pwdata[NODES_W-1:0];
		end
	end

	assign prdata = sel_nodes ? PDATA_W'(nodes_q) : '0;

	pli_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cmd(cmd),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop)
	);

	pli_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	pli_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop),
		.nodes_in_use(nodes_q),
		.div_req(div_req),
		.div_rsp(div_rsp),
		.rsp(rsp)
	);

endmodule

FILE: sv/pli_checker.sv
`include "assert_macros.svh"

module pli_checker import pli_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [DATA_W-1:0] rsp_value,
	input logic [STATUS_W-1:0] rsp_status,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic pready,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	input logic [PDATA_W-1:0] prdata
);

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	`ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_value) && $stable(rsp_status))

	// A read right after a write to the node count returns what was written.
	`ASSERT_NEXT(a_cfg_readback, clk, arst_n, psel && penable && pwrite && pready && paddr == ADDR_NODES, !(psel && !pwrite && paddr == ADDR_NODES) || prdata[NODES_W-1:0] == $past(pwdata[NODES_W-1:0]))

	`ASSERT_ALWAYS(a_reset_quiet, clk, arst_n || !rsp_valid)

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_value(rsp.interp_value),
	.rsp_status(rsp.status),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.pready(pready),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata)
);
